// File: hdl/qrs_pkg.sv
// Shared widths and types for the quadratic root solver.
package qrs_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // exact discriminant b^2 - 4ac and its floor square root
    localparam int DISC_W   = 2 * WORD_WIDTH + 2;
    localparam int ROOT_W   = DISC_W / 2;
    localparam int SQ_REM_W = ROOT_W + 3;

    // m = |b| + sqrt(disc), numerators and quotients of the two divisions
    localparam int MM_W  = WORD_WIDTH + 2;
    localparam int DEN_W = MM_W;
    localparam int QUO_W = WORD_WIDTH + FRAC_BITS + 1;

    typedef struct packed {
        logic degen;
        logic nodisc;
        logic dzero;
        logic neg0;
        logic neg1;
    } t_flags;

    typedef struct packed {
        t_flags                  flags;
        logic [WORD_WIDTH-1:0]   am;
        logic [WORD_WIDTH-1:0]   bm;
        logic [WORD_WIDTH-1:0]   cm;
    } t_side;

    typedef struct packed {
        logic [DISC_W-1:0]   rad;
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
        t_side               side;
    } t_sq;

    typedef struct packed {
        logic [QUO_W-1:0] num;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } t_div_lane;

    typedef struct packed {
        t_div_lane l0;
        t_div_lane l1;
        t_flags    flags;
    } t_div;

endpackage

// File: hdl/qrs_front.sv
// Front end: coefficient magnitudes, the two products and the exact discriminant.
module qrs_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [qrs_pkg::WORD_WIDTH-1:0] i_a,
    input  logic [qrs_pkg::WORD_WIDTH-1:0] i_b,
    input  logic [qrs_pkg::WORD_WIDTH-1:0] i_c,
    output logic                           o_valid,
    output qrs_pkg::t_sq                   o_data
);

    localparam int W = qrs_pkg::WORD_WIDTH;
    localparam int D = qrs_pkg::DISC_W;

    logic         r_a_v, r_b_v, r_c_v;
    logic [W-1:0] r_am, r_bm, r_cm, r_am2, r_bm2, r_cm2;
    logic         r_an, r_bn, r_cn, r_an2, r_bn2, r_cn2;
    logic [2*W-1:0] r_bsq, r_ac;
    qrs_pkg::t_sq r_out;
    qrs_pkg::t_sq n_out;

    logic [D-1:0] bsq_x, ac4_x;
    logic         mneg;

    always_comb begin
        bsq_x = {2'b00, r_bsq};
        ac4_x = {r_ac, 2'b00};
        mneg  = r_bn2 || (r_bm2 == '0);
        n_out = '0;
        n_out.side.am = r_am2;
        n_out.side.bm = r_bm2;
        n_out.side.cm = r_cm2;
        n_out.side.flags.degen = (r_am2 == '0);
        n_out.side.flags.neg0  = (mneg == r_an2);
        n_out.side.flags.neg1  = (r_cn2 == mneg);
        if (r_an2 != r_cn2) begin
            n_out.rad = bsq_x + ac4_x;
        end else if (bsq_x < ac4_x) begin
            n_out.side.flags.nodisc = 1'b1;
        end else begin
            n_out.rad = bsq_x - ac4_x;
        end
        n_out.side.flags.dzero = (n_out.rad == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_an  <= i_a[W-1];
            r_bn  <= i_b[W-1];
            r_cn  <= i_c[W-1];
            r_am  <= i_a[W-1] ? (~i_a + 1'b1) : i_a;
            r_bm  <= i_b[W-1] ? (~i_b + 1'b1) : i_b;
            r_cm  <= i_c[W-1] ? (~i_c + 1'b1) : i_c;
            r_bsq <= r_bm * r_bm;
            r_ac  <= r_am * r_cm;
            r_am2 <= r_am;
            r_bm2 <= r_bm;
            r_cm2 <= r_cm;
            r_an2 <= r_an;
            r_bn2 <= r_bn;
            r_cn2 <= r_cn;
            r_out <= n_out;
        end
    end

    assign o_valid = r_c_v;
    assign o_data  = r_out;

endmodule

// File: hdl/qrs_sqrt_cell.sv
// One square root cell: settles one root bit from two radicand bits.
module qrs_sqrt_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  qrs_pkg::t_sq i_data,
    output logic         o_valid,
    output qrs_pkg::t_sq o_data
);

    localparam int D  = qrs_pkg::DISC_W;
    localparam int RW = qrs_pkg::SQ_REM_W;
    localparam int QW = qrs_pkg::ROOT_W;

    logic         r_valid;
    qrs_pkg::t_sq r_data;
    qrs_pkg::t_sq n_data;
    logic [RW-1:0] rem_sh, trial;

    always_comb begin
        rem_sh = {i_data.rem[RW-3:0], i_data.rad[D-1 -: 2]};
        trial  = {{(RW-QW-2){1'b0}}, i_data.root, 2'b01};
        n_data = i_data;
        n_data.rad = {i_data.rad[D-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n_data.rem  = rem_sh - trial;
            n_data.root = {i_data.root[QW-2:0], 1'b1};
        end else begin
            n_data.rem  = rem_sh;
            n_data.root = {i_data.root[QW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: hdl/qrs_div_cell.sv
// One divider cell: settles one quotient bit in each of the two root divisions.
module qrs_div_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  qrs_pkg::t_div i_data,
    output logic          o_valid,
    output qrs_pkg::t_div o_data
);

    localparam int NW = qrs_pkg::QUO_W;
    localparam int DW = qrs_pkg::DEN_W;

    logic          r_valid;
    qrs_pkg::t_div r_data;
    qrs_pkg::t_div n_data;

    function automatic qrs_pkg::t_div_lane step(input qrs_pkg::t_div_lane l);
        qrs_pkg::t_div_lane r;
        logic [DW:0]        rem_sh;
        r      = l;
        rem_sh = {l.rem, l.num[NW-1]};
        r.num  = {l.num[NW-2:0], 1'b0};
        if (rem_sh >= {1'b0, l.den}) begin
            r.rem = DW'(rem_sh - {1'b0, l.den});
            r.quo = {l.quo[NW-2:0], 1'b1};
        end else begin
            r.rem = rem_sh[DW-1:0];
            r.quo = {l.quo[NW-2:0], 1'b0};
        end
        return r;
    endfunction

    always_comb begin
        n_data       = i_data;
        n_data.l0    = step(i_data.l0);
        n_data.l1    = step(i_data.l1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: hdl/quadratic_root_solver.sv
// Top level of the quadratic root solver: cell chains, rounding and result register.
// Takes one coefficient set (a, b, c in signed Q16.16) per cycle while not stalled and returns
// found, both roots in ascending order and a flag for a zero leading coefficient.
// The pipe has three front stages (magnitudes, products, discriminant),
// a chain of 33 square root cells (one root bit each), one stage forming
// |b| + sqrt, a chain of 49 divider cells that settle one bit of both root
// quotients each, a rounding stage and the result register. The whole pipe
// advances together and holds while a result waits under stall.
module quadratic_root_solver (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [qrs_pkg::WORD_WIDTH-1:0] i_coef_a,
    input  logic [qrs_pkg::WORD_WIDTH-1:0] i_coef_b,
    input  logic [qrs_pkg::WORD_WIDTH-1:0] i_coef_c,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_found,
    output logic [qrs_pkg::WORD_WIDTH-1:0] o_root_low,
    output logic [qrs_pkg::WORD_WIDTH-1:0] o_root_high,
    output logic                           o_degenerate
);

    localparam int W  = qrs_pkg::WORD_WIDTH;
    localparam int F  = qrs_pkg::FRAC_BITS;
    localparam int QW = qrs_pkg::ROOT_W;
    localparam int NW = qrs_pkg::QUO_W;
    localparam int DW = qrs_pkg::DEN_W;
    localparam int MW = qrs_pkg::MM_W;

    logic en;

    logic          sq_v [QW+1];
    qrs_pkg::t_sq  sq_d [QW+1];
    logic          dv_v [NW+1];
    qrs_pkg::t_div dv_d [NW+1];

    logic          r_mm_v;
    qrs_pkg::t_div r_mm;
    logic [MW-1:0] mm;

    logic          r_rd_v;
    logic [W-1:0]  r_x0, r_x1;
    qrs_pkg::t_flags r_rd_flags;

    logic          r_out_v;
    logic          r_found, r_degen;
    logic [W-1:0]  r_lo, r_hi;

    assign en      = !(r_out_v && i_stall);
    assign o_stall = !en;

    qrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_a     (i_coef_a),
        .i_b     (i_coef_b),
        .i_c     (i_coef_c),
        .o_valid (sq_v[0]),
        .o_data  (sq_d[0])
    );

    for (genvar g = 0; g < QW; g++) begin : g_sqrt
        qrs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_v[g]),
            .i_data  (sq_d[g]),
            .o_valid (sq_v[g+1]),
            .o_data  (sq_d[g+1])
        );
    end

    // set up both divisions: m*2^(F-1) / |a| and |c|*2^(F+1) / m
    assign mm = {2'b00, sq_d[QW].side.bm} + {{(MW-QW){1'b0}}, sq_d[QW].root};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mm_v <= 1'b0;
        end else if (en) begin
            r_mm_v <= sq_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mm.flags  <= sq_d[QW].side.flags;
            r_mm.l0.num <= {mm, {(F-1){1'b0}}};
            r_mm.l0.den <= {{(DW-W){1'b0}}, sq_d[QW].side.am};
            r_mm.l0.rem <= '0;
            r_mm.l0.quo <= '0;
            r_mm.l1.num <= {sq_d[QW].side.cm, {(F+1){1'b0}}};
            r_mm.l1.den <= mm;
            r_mm.l1.rem <= '0;
            r_mm.l1.quo <= '0;
        end
    end

    assign dv_v[0] = r_mm_v;
    assign dv_d[0] = r_mm;

    for (genvar g = 0; g < NW; g++) begin : g_div
        qrs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_v[g]),
            .i_data  (dv_d[g]),
            .o_valid (dv_v[g+1]),
            .o_data  (dv_d[g+1])
        );
    end

    // round half away from zero, saturate, apply sign
    function automatic logic [W-1:0] round_sat(input qrs_pkg::t_div_lane l, input logic neg);
        logic [DW:0]   r2;
        logic [NW:0]   q;
        logic [NW:0]   limit;
        logic [W-1:0]  mag;
        r2    = {l.rem, 1'b0};
        q     = {1'b0, l.quo} + {{NW{1'b0}}, (r2 >= {1'b0, l.den})};
        limit = neg ? {{(NW-W+1){1'b0}}, 1'b1, {(W-1){1'b0}}}
                    : {{(NW-W+1){1'b0}}, 1'b0, {(W-1){1'b1}}};
        mag   = (q > limit) ? limit[W-1:0] : q[W-1:0];
        return neg ? (~mag + 1'b1) : mag;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else if (en) begin
            r_rd_v <= dv_v[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0       <= round_sat(dv_d[NW].l0, dv_d[NW].flags.neg0);
            r_x1       <= round_sat(dv_d[NW].l1, dv_d[NW].flags.neg1);
            r_rd_flags <= dv_d[NW].flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_degen <= r_rd_flags.degen;
            r_found <= !r_rd_flags.degen && !r_rd_flags.nodisc;
            if (r_rd_flags.degen || r_rd_flags.nodisc) begin
                r_lo <= '0;
                r_hi <= '0;
            end else if (r_rd_flags.dzero) begin
                r_lo <= r_x0;
                r_hi <= r_x0;
            end else if ($signed(r_x0) > $signed(r_x1)) begin
                r_lo <= r_x1;
                r_hi <= r_x0;
            end else begin
                r_lo <= r_x0;
                r_hi <= r_x1;
            end
        end
    end

    assign o_valid      = r_out_v;
    assign o_found      = r_found;
    assign o_root_low   = r_lo;
    assign o_root_high  = r_hi;
    assign o_degenerate = r_degen;

endmodule
